### sv/point_in_convex_polyhedron_defines.svh
// Assertion macros shared by the point-in-polyhedron block.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef POINT_IN_CONVEX_POLYHEDRON_DEFINES_SVH
`define POINT_IN_CONVEX_POLYHEDRON_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent holds, so the consequent holds in the same cycle.
`define PCP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent holds, so the consequent holds in the next cycle.
`define PCP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PCP_ASSERT_NOW(lbl, ante, cons)
`define PCP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### sv/pcp_pkg.sv
package pcp_pkg;

    // Table size and number format.
    localparam int MAX_PLANES = 8;
    localparam int COEF_BITS  = 24;
    localparam int SLOT_BITS  = 3;
    localparam int CFG_BITS   = 4;

    // Exact product and four-term sum widths.
    localparam int PROD_BITS = 2 * COEF_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;

    // Number of planes checked after reset.
    localparam logic [CFG_BITS-1:0] ACTIVE_RESET = CFG_BITS'(6);

    // Kind of a request beat.
    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TEST = 1'b1
    } req_type_t;

    // Beat that travels down the chain of plane cells.
    typedef struct packed {
        req_type_t                     kind;
        logic [SLOT_BITS-1:0]          slot;
        logic signed [COEF_BITS-1:0]   x;
        logic signed [COEF_BITS-1:0]   y;
        logic signed [COEF_BITS-1:0]   z;
        logic signed [COEF_BITS-1:0]   w;
        logic                          in_hull;
    } pcp_beat_t;

endpackage

### sv/pcp_if.sv
// Request channel: plane loads and point tests.
interface pcp_req_if;
    logic                                   valid;
    logic                                   ready;
    pcp_pkg::req_type_t                     req_type;
    logic [pcp_pkg::SLOT_BITS-1:0]          plane_slot;
    logic signed [pcp_pkg::COEF_BITS-1:0]   coef_x;
    logic signed [pcp_pkg::COEF_BITS-1:0]   coef_y;
    logic signed [pcp_pkg::COEF_BITS-1:0]   coef_z;
    logic signed [pcp_pkg::COEF_BITS-1:0]   coef_w;

    modport source (
        output valid, req_type, plane_slot, coef_x, coef_y, coef_z, coef_w,
        input  ready
    );
    modport sink (
        input  valid, req_type, plane_slot, coef_x, coef_y, coef_z, coef_w,
        output ready
    );
endinterface

// Result channel: one beat per point test.
interface pcp_res_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (
        output valid, inside_res,
        input  ready
    );
    modport sink (
        input  valid, inside_res,
        output ready
    );
endinterface

// Configuration write channel for the active plane count.
interface pcp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pcp_pkg::CFG_BITS-1:0]  active_planes;

    modport source (
        output valid, active_planes,
        input  ready
    );
    modport sink (
        input  valid, active_planes,
        output ready
    );
endinterface

### sv/pcp_cell.sv
// One plane of the table. Stage one forms the four exact products,
// stage two adds them and clears the inside flag on a positive sum when the cell is active.
module pcp_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic [pcp_pkg::SLOT_BITS-1:0]   idx,
    input  logic [pcp_pkg::CFG_BITS-1:0]    active_planes,
    input  logic                            in_valid,
    input  pcp_pkg::pcp_beat_t              in_beat,
    output logic                            out_valid,
    output pcp_pkg::pcp_beat_t              out_beat
);

    logic signed [pcp_pkg::COEF_BITS-1:0] plane_nx_reg;
    logic signed [pcp_pkg::COEF_BITS-1:0] plane_ny_reg;
    logic signed [pcp_pkg::COEF_BITS-1:0] plane_nz_reg;
    logic signed [pcp_pkg::COEF_BITS-1:0] plane_off_reg;

    logic signed [pcp_pkg::PROD_BITS-1:0] prod_x_reg, prod_x_next;
    logic signed [pcp_pkg::PROD_BITS-1:0] prod_y_reg, prod_y_next;
    logic signed [pcp_pkg::PROD_BITS-1:0] prod_z_reg, prod_z_next;
    logic signed [pcp_pkg::PROD_BITS-1:0] prod_w_reg, prod_w_next;

    logic                 s1_valid_reg;
    pcp_pkg::pcp_beat_t   s1_beat_reg;
    logic                 out_valid_reg;
    pcp_pkg::pcp_beat_t   out_beat_reg, out_beat_next;

    logic                                 load_hit;
    logic                                 cell_active;
    logic signed [pcp_pkg::SUM_BITS-1:0]  dot_sum;
    logic                                 dot_pos;

    // A load beat for this slot writes the plane as it enters the cell.
    assign load_hit = adv && in_valid && (in_beat.kind == pcp_pkg::REQ_LOAD)
                      && (in_beat.slot == idx);

    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            plane_nx_reg  <= in_beat.x;
            plane_ny_reg  <= in_beat.y;
            plane_nz_reg  <= in_beat.z;
            plane_off_reg <= in_beat.w;
        end
    end

    // Stage one: exact products of the plane with the point.
    always_comb
    begin
        prod_x_next = $signed(plane_nx_reg)  * $signed(in_beat.x);
        prod_y_next = $signed(plane_ny_reg)  * $signed(in_beat.y);
        prod_z_next = $signed(plane_nz_reg)  * $signed(in_beat.z);
        prod_w_next = $signed(plane_off_reg) * $signed(in_beat.w);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_x_reg  <= prod_x_next;
            prod_y_reg  <= prod_y_next;
            prod_z_reg  <= prod_z_next;
            prod_w_reg  <= prod_w_next;
            s1_beat_reg <= in_beat;
        end
    end

    // Stage two: four-term sum and the sign test against this plane.
    assign cell_active = ({1'b0, idx} < active_planes);

    always_comb
    begin
        dot_sum = pcp_pkg::SUM_BITS'(prod_x_reg) + pcp_pkg::SUM_BITS'(prod_y_reg)
                + pcp_pkg::SUM_BITS'(prod_z_reg) + pcp_pkg::SUM_BITS'(prod_w_reg);
        dot_pos = !dot_sum[pcp_pkg::SUM_BITS-1] && (dot_sum != '0);
        out_beat_next = s1_beat_reg;
        out_beat_next.in_hull = s1_beat_reg.in_hull && !(cell_active && dot_pos);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

    // Beat occupancy of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

endmodule

### sv/point_in_convex_polyhedron.sv
// An accepted test beat passes both stage registers of every cell, then the result register.
// Throughput: one beat per cycle while the result is not stalled; every plane cell has a two-stage multiply-add.
// A stalled result holds the whole chain of cells until it is taken.
// Reset clears all beat occupancy and sets the active plane count to 6;
// the plane table holds no defined value until loaded.
`include "point_in_convex_polyhedron_defines.svh"

module point_in_convex_polyhedron (
    input  logic        clk,
    input  logic        rst_n,
    pcp_req_if.sink     req,
    pcp_res_if.source   res,
    pcp_cfg_if.sink     cfg
);

    localparam int NCELL  = pcp_pkg::MAX_PLANES;
    localparam int SLOT_W = pcp_pkg::SLOT_BITS;

    logic                              adv;
    logic [pcp_pkg::CFG_BITS-1:0]      active_planes_reg;
    logic                              chain_valid [0:NCELL];
    pcp_pkg::pcp_beat_t                chain_beat  [0:NCELL];
    logic                              tail_valid;
    pcp_pkg::pcp_beat_t                tail_beat;
    logic                              res_valid_reg, res_valid_next;
    logic                              res_inside_reg, res_inside_next;

    // Configuration register; always ready.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_planes_reg <= pcp_pkg::ACTIVE_RESET;
        end
        else if (cfg.valid)
        begin
            active_planes_reg <= cfg.active_planes;
        end
    end

    // The chain moves whenever the result register is empty or being taken.
    assign adv       = !res_valid_reg || res.ready;
    assign req.ready = adv;

    // Entry beat: the inside flag starts as the positive-w condition.
    always_comb
    begin
        chain_valid[0]        = req.valid;
        chain_beat[0].kind    = req.req_type;
        chain_beat[0].slot    = req.plane_slot;
        chain_beat[0].x       = req.coef_x;
        chain_beat[0].y       = req.coef_y;
        chain_beat[0].z       = req.coef_z;
        chain_beat[0].w       = req.coef_w;
        chain_beat[0].in_hull = !req.coef_w[pcp_pkg::COEF_BITS-1] && (req.coef_w != '0);
    end

    // Row of plane cells, cell k holding table entry k.
    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        pcp_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .adv           (adv),
            .idx           (SLOT_W'(k)),
            .active_planes (active_planes_reg),
            .in_valid      (chain_valid[k]),
            .in_beat       (chain_beat[k]),
            .out_valid     (chain_valid[k+1]),
            .out_beat      (chain_beat[k+1])
        );
    end

    assign tail_valid = chain_valid[NCELL];
    assign tail_beat  = chain_beat[NCELL];

    // Result register: only test beats leave the chain as results.
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_inside_next = res_inside_reg;
        if (adv)
        begin
            res_valid_next  = tail_valid && (tail_beat.kind == pcp_pkg::REQ_TEST);
            res_inside_next = tail_beat.in_hull;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_inside_reg <= res_inside_next;
    end

    assign res.valid      = res_valid_reg;
    assign res.inside_res = res_inside_reg;

    // A waiting result blocks new requests.
    `PCP_ASSERT_NOW(a_stall_blocks_input, res.valid && !res.ready, !req.ready)
    // A test beat leaving the chain becomes a result.
    `PCP_ASSERT_NEXT(a_test_gives_result, adv && tail_valid && tail_beat.kind == pcp_pkg::REQ_TEST, res.valid)
    // A load beat leaving the chain gives no result.
    `PCP_ASSERT_NEXT(a_load_no_result, adv && tail_valid && tail_beat.kind == pcp_pkg::REQ_LOAD, !res.valid)

endmodule
